// File: rtl/torus_vertex_generator_core_assert.svh
// assertion macros for the checker of the torus vertex generator
// no dependencies; include by bare file name inside a module body
`ifndef TORUS_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define TORUS_VERTEX_GENERATOR_CORE_ASSERT_SVH
// same-cycle implication, disabled during reset
`define TVG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define TVG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// what must hold in the cycle after reset
`define TVG_ASSERT_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);
`endif

// File: rtl/tvg_pkg.sv
// shared widths, constants and small tables of the torus vertex generator
// no dependencies
package tvg_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_SUBDIV = 360;
  localparam int MIN_COUNT  = 3;
  localparam int MIN_OUTER  = ((1 << FRAC_BITS) + 50) / 100;
  localparam int MIN_INNER  = ((1 << FRAC_BITS) + 100) / 200;

  localparam int RAD_W     = 23;
  localparam int CNT_W     = 9;
  localparam int VERT_W    = 24;
  localparam int PHASE_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int TRIG_W    = 32;
  localparam int TRIG_DEPTH = 8;
  localparam int TERMS     = 7;

  localparam logic [34:0] TWO_PI_Q32 = 35'h6487ED511;

  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RINGS = 2'd3;

  localparam logic [RAD_W-1:0] RST_OUTER = 23'd65536;
  localparam logic [RAD_W-1:0] RST_INNER = 23'd32768;
  localparam logic [CNT_W-1:0] RST_COUNT = 9'd12;

  // reciprocals ceil(2^s/d) of the sine series denominators d = (2k)(2k+1)
  // s = 31 + ceil(log2 d); the quotient is exact for dividends below 2^31
  function automatic logic [31:0] sin_magic(input logic [2:0] k);
    case (k)
      3'd1:    sin_magic = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
      3'd2:    sin_magic = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
      3'd3:    sin_magic = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
      3'd4:    sin_magic = 32'(((64'd1 << 38) + 64'd71) / 64'd72);
      3'd5:    sin_magic = 32'(((64'd1 << 38) + 64'd109) / 64'd110);
      3'd6:    sin_magic = 32'(((64'd1 << 39) + 64'd155) / 64'd156);
      3'd7:    sin_magic = 32'(((64'd1 << 39) + 64'd209) / 64'd210);
      default: sin_magic = 32'd0;
    endcase
  endfunction

  function automatic logic [5:0] sin_shift(input logic [2:0] k);
    case (k)
      3'd1:    sin_shift = 6'd34;
      3'd2:    sin_shift = 6'd36;
      3'd3:    sin_shift = 6'd37;
      3'd4:    sin_shift = 6'd38;
      3'd5:    sin_shift = 6'd38;
      3'd6:    sin_shift = 6'd39;
      3'd7:    sin_shift = 6'd39;
      default: sin_shift = 6'd32;
    endcase
  endfunction

  // same for the cosine series denominators d = (2k-1)(2k)
  function automatic logic [31:0] cos_magic(input logic [2:0] k);
    case (k)
      3'd1:    cos_magic = 32'(((64'd1 << 32) + 64'd1) / 64'd2);
      3'd2:    cos_magic = 32'(((64'd1 << 35) + 64'd11) / 64'd12);
      3'd3:    cos_magic = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
      3'd4:    cos_magic = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
      3'd5:    cos_magic = 32'(((64'd1 << 38) + 64'd89) / 64'd90);
      3'd6:    cos_magic = 32'(((64'd1 << 39) + 64'd131) / 64'd132);
      3'd7:    cos_magic = 32'(((64'd1 << 39) + 64'd181) / 64'd182);
      default: cos_magic = 32'd0;
    endcase
  endfunction

  function automatic logic [5:0] cos_shift(input logic [2:0] k);
    case (k)
      3'd1:    cos_shift = 6'd32;
      3'd2:    cos_shift = 6'd35;
      3'd3:    cos_shift = 6'd36;
      3'd4:    cos_shift = 6'd37;
      3'd5:    cos_shift = 6'd38;
      3'd6:    cos_shift = 6'd39;
      3'd7:    cos_shift = 6'd39;
      default: cos_shift = 6'd32;
    endcase
  endfunction

endpackage

// File: rtl/tvg_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on tvg_pkg for default sizes
module tvg_ram
  import tvg_pkg::*;
#(
  parameter int WIDTH = TRIG_W,
  parameter int DEPTH = TRIG_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/torus_vertex_generator_core.sv
// torus vertex generator: one quad (six vertices) per advance word
// depends on tvg_pkg and tvg_ram
//
//  port group   dir  handshake            payload
//  cfg          in   cfg_we               cfg_index, cfg_data
//  in           in   in_valid/in_ready    restart
//  out          out  out_valid/out_ready  vert_x, vert_y, vert_z, last_of_quad, mesh_done
//
// a quad runs 4 phases (a radix-2 divide by the count, then 7 series steps with the
// term divides done by reciprocal multiply), then reads each vertex out of the trig ram;
// the next advance word is taken only once the sixth vertex is in the output register.
// an advance word past the end of the mesh is accepted and gives no word.
// reset is synchronous; config registers come back to their reset values.
// a stalled output holds the walk; the last vertex sits in the output register while
// the next word is accepted.
module torus_vertex_generator_core
  import tvg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [RAD_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VERT_W-1:0] vert_x,
  output logic signed [VERT_W-1:0] vert_y,
  output logic signed [VERT_W-1:0] vert_z,
  output logic                     last_of_quad,
  output logic                     mesh_done
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PHASE   = 5'd1;
  localparam logic [4:0] S_PH_WAIT = 5'd2;
  localparam logic [4:0] S_A       = 5'd3;
  localparam logic [4:0] S_X2      = 5'd4;
  localparam logic [4:0] S_TS      = 5'd5;
  localparam logic [4:0] S_TS_WAIT = 5'd6;
  localparam logic [4:0] S_TC      = 5'd7;
  localparam logic [4:0] S_TC_WAIT = 5'd8;
  localparam logic [4:0] S_FIN     = 5'd9;
  localparam logic [4:0] S_WR_COS  = 5'd10;
  localparam logic [4:0] S_V_RD0   = 5'd11;
  localparam logic [4:0] S_V_RD1   = 5'd12;
  localparam logic [4:0] S_V_RD2   = 5'd13;
  localparam logic [4:0] S_V_RD3   = 5'd14;
  localparam logic [4:0] S_V_RD4   = 5'd15;
  localparam logic [4:0] S_V_Z     = 5'd16;
  localparam logic [4:0] S_V_OUT   = 5'd17;

  localparam int DIV_N = 33;
  localparam int AW    = $clog2(TRIG_DEPTH);

  // configuration registers
  logic [RAD_W-1:0] outer_radius, inner_radius;
  logic [CNT_W-1:0] faces_per_ring, ring_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_radius   <= RST_OUTER;
      inner_radius   <= RST_INNER;
      faces_per_ring <= RST_COUNT;
      ring_count     <= RST_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTER: outer_radius   <= cfg_data;
        REG_INNER: inner_radius   <= cfg_data;
        REG_FACES: faces_per_ring <= cfg_data[CNT_W-1:0];
        REG_RINGS: ring_count     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [CNT_W-1:0] na_c, nb_c;
  logic [RAD_W-1:0] o_c, i_c, o_s, i_s;
  logic [RAD_W:0]   c2_c;
  logic [RAD_W-1:0] t2_c;

  always_comb begin
    na_c = (faces_per_ring < CNT_W'(MIN_COUNT)) ? CNT_W'(MIN_COUNT) :
           (faces_per_ring > CNT_W'(MAX_SUBDIV)) ? CNT_W'(MAX_SUBDIV) : faces_per_ring;
    nb_c = (ring_count < CNT_W'(MIN_COUNT)) ? CNT_W'(MIN_COUNT) :
           (ring_count > CNT_W'(MAX_SUBDIV)) ? CNT_W'(MAX_SUBDIV) : ring_count;
    o_c  = (outer_radius < RAD_W'(MIN_OUTER)) ? RAD_W'(MIN_OUTER) : outer_radius;
    i_c  = (inner_radius < RAD_W'(MIN_INNER)) ? RAD_W'(MIN_INNER) : inner_radius;
    o_s  = (i_c > o_c) ? i_c : o_c;
    i_s  = (i_c > o_c) ? o_c : i_c;
    c2_c = {1'b0, o_s} + {1'b0, i_s};
    t2_c = o_s - i_s;
  end

  // walk state
  logic [4:0]       state;
  logic [CNT_W-1:0] face_pos, ring_pos;
  logic             finished;
  logic [1:0]       j;
  logic [2:0]       k;
  logic [2:0]       v;

  logic             accept;
  logic [CNT_W-1:0] face_w, ring_w, face_a, ring_a, face_n;
  logic             fin_w, wrap_a, end_a, wrap_n, end_n;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    face_w = restart ? CNT_W'(1) : face_pos;
    ring_w = restart ? CNT_W'(1) : ring_pos;
    fin_w  = restart ? 1'b0 : finished;
    wrap_a = (face_w > na_c) || (face_w == '0);
    face_a = wrap_a ? CNT_W'(1) : face_w;
    ring_a = wrap_a ? ring_w + CNT_W'(1) : ring_w;
    end_a  = (ring_a > nb_c) || (ring_a == '0);
    face_n = face_a + CNT_W'(1);
    wrap_n = face_n > na_c;
    end_n  = (ring_a + CNT_W'(1)) > nb_c;
  end

  // quad context
  logic [CNT_W-1:0] cur_face, cur_ring, na_q, nb_q;
  logic [RAD_W:0]   c2_q;
  logic [RAD_W-1:0] t2_q;
  logic             quad_done;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_face  <= face_a;
      cur_ring  <= ring_a;
      na_q      <= na_c;
      nb_q      <= nb_c;
      c2_q      <= c2_c;
      t2_q      <= t2_c;
      quad_done <= wrap_n && end_n;
    end
  end

  // shared multiplier, registered product
  logic signed [35:0] op_a;
  logic signed [32:0] op_b;
  logic signed [68:0] mul_p;

  always_ff @(posedge clk) begin
    mul_p <= op_a * op_b;
  end

  // shared radix-2 divider
  logic             div_start;
  logic [DIV_N-1:0] div_num;
  logic [CNT_W-1:0] div_den;
  logic [DIV_N-1:0] div_quo;
  logic [CNT_W-1:0] div_rem, div_den_q;
  logic [5:0]       div_cnt;
  logic             div_busy;
  logic [CNT_W:0]   div_sh;

  assign div_busy = (div_cnt != '0);
  assign div_sh   = {div_rem, div_quo[DIV_N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      div_cnt <= 6'(DIV_N);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_quo   <= div_num;
      div_rem   <= '0;
      div_den_q <= div_den;
    end else if (div_busy) begin
      if (div_sh >= {1'b0, div_den_q}) begin
        div_rem <= CNT_W'(div_sh - {1'b0, div_den_q});
        div_quo <= {div_quo[DIV_N-2:0], 1'b1};
      end else begin
        div_rem <= div_sh[CNT_W-1:0];
        div_quo <= {div_quo[DIV_N-2:0], 1'b0};
      end
    end
  end

  // phase setup
  logic [CNT_W-1:0] k_sel, n_sel;
  always_comb begin
    case (j)
      2'd0:    k_sel = cur_face - CNT_W'(1);
      2'd1:    k_sel = cur_face;
      2'd2:    k_sel = cur_ring - CNT_W'(1);
      default: k_sel = cur_ring;
    endcase
    n_sel = j[1] ? nb_q : na_q;
  end

  // series datapath
  logic [21:0]        u_c, r_c;
  logic               swap_c;
  logic [30:0]        a_c, x2_c;
  logic [30:0]        x2;
  logic [32:0]        ts, tc;
  logic signed [33:0] ss, sc;
  logic               swap_q;
  logic [1:0]         quad_q;
  logic [5:0]         q_sh;
  logic [32:0]        q_c;

  assign u_c    = div_quo[21:0];
  assign swap_c = u_c[21];
  assign r_c    = swap_c ? 22'(23'h400000 - {1'b0, u_c}) : u_c;
  assign a_c    = mul_p[55:25];
  assign x2_c   = mul_p[61:31];

  // series term quotient from the reciprocal product
  assign q_sh = (state == S_TS_WAIT) ? sin_shift(k) : cos_shift(k);
  assign q_c  = 33'(mul_p[62:0] >> q_sh);

  // clamp, round to q2.30, fold octant and quadrant
  logic signed [33:0] ss_cl, sc_cl;
  logic [30:0]        s_h, c_h, s0, c0;
  logic signed [31:0] s_pos, c_pos, sin_c, cos_c;
  logic signed [31:0] cos_q;

  always_comb begin
    ss_cl = (ss < 34'sd0) ? 34'sd0 : (ss > 34'sh80000000) ? 34'sh80000000 : ss;
    sc_cl = (sc < 34'sd0) ? 34'sd0 : (sc > 34'sh80000000) ? 34'sh80000000 : sc;
    s_h   = 31'((ss_cl + 34'sd1) >>> 1);
    c_h   = 31'((sc_cl + 34'sd1) >>> 1);
    s0    = swap_q ? c_h : s_h;
    c0    = swap_q ? s_h : c_h;
    s_pos = {1'b0, s0};
    c_pos = {1'b0, c0};
    case (quad_q)
      2'd0:    begin sin_c = s_pos;  cos_c = c_pos;  end
      2'd1:    begin sin_c = c_pos;  cos_c = -s_pos; end
      2'd2:    begin sin_c = -s_pos; cos_c = -c_pos; end
      default: begin sin_c = -c_pos; cos_c = s_pos;  end
    endcase
  end

  // trig scratch ram: {ring, which, is_cos}
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [TRIG_W-1:0] ram_wdata, ram_rdata;

  tvg_ram #(
    .WIDTH(TRIG_W),
    .DEPTH(TRIG_DEPTH)
  ) u_trig_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // vertex datapath
  logic              fs, rs;
  logic [56:0]       a_v;
  logic [31:0]       m_q;
  logic [TRIG_W-1:0] sp_q;
  logic signed [VERT_W-1:0] x_q, y_q;
  logic              out_load;

  assign fs  = (v == 3'd2) || (v == 3'd3) || (v == 3'd5);
  assign rs  = (v == 3'd1) || (v == 3'd4) || (v == 3'd5);
  assign a_v = {3'b0, c2_q, 30'b0} + 57'(unsigned'(mul_p[56:0])) + (57'd1 << 23);
  assign out_load = (state == S_V_OUT) && (!out_valid || out_ready);

  function automatic logic signed [VERT_W-1:0] rnd_sat(input logic signed [68:0] val,
                                                       input int sh);
    logic [68:0]        mag;
    logic [68:0]        rr;
    logic signed [69:0] res;
    mag = val[68] ? 69'(-val) : 69'(val);
    rr  = (mag + (69'd1 << (sh - 1))) >> sh;
    res = val[68] ? -$signed({1'b0, rr}) : $signed({1'b0, rr});
    if (res > 70'sd8388607) begin
      rnd_sat = 24'sh7FFFFF;
    end else if (res < -70'sd8388608) begin
      rnd_sat = -24'sh800000;
    end else begin
      rnd_sat = res[VERT_W-1:0];
    end
  endfunction

  // per-state selection of multiplier, divider and ram ports
  always_comb begin
    op_a      = '0;
    op_b      = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_PHASE: begin
        div_start = 1'b1;
        div_num   = {k_sel, 24'b0} + DIV_N'(n_sel >> 1);
        div_den   = n_sel;
      end
      S_PH_WAIT: begin
        op_a = $signed({1'b0, TWO_PI_Q32});
        op_b = $signed({11'b0, r_c});
      end
      S_A: begin
        op_a = $signed({5'b0, a_c});
        op_b = $signed({2'b0, a_c});
      end
      S_X2: begin
        op_a = $signed({3'b0, ts});
        op_b = $signed({2'b0, x2_c});
      end
      S_TS: begin
        op_a = $signed({5'b0, mul_p[61:31]});
        op_b = $signed({1'b0, sin_magic(k)});
      end
      S_TS_WAIT: begin
        op_a = $signed({3'b0, tc});
        op_b = $signed({2'b0, x2});
      end
      S_TC: begin
        op_a = $signed({5'b0, mul_p[61:31]});
        op_b = $signed({1'b0, cos_magic(k)});
      end
      S_TC_WAIT: begin
        op_a = $signed({3'b0, ts});
        op_b = $signed({2'b0, x2});
      end
      S_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = {j, 1'b0};
        ram_wdata = sin_c;
      end
      S_WR_COS: begin
        ram_we    = 1'b1;
        ram_waddr = {j, 1'b1};
        ram_wdata = cos_q;
      end
      S_V_RD0: begin
        ram_raddr = {1'b0, fs, 1'b1};
      end
      S_V_RD1: begin
        ram_raddr = {1'b0, fs, 1'b0};
        op_a = $signed({13'b0, t2_q});
        op_b = $signed({ram_rdata[TRIG_W-1], ram_rdata});
      end
      S_V_RD2: begin
        ram_raddr = {1'b1, rs, 1'b1};
      end
      S_V_RD3: begin
        ram_raddr = {1'b1, rs, 1'b0};
        op_a = $signed({4'b0, m_q});
        op_b = $signed({ram_rdata[TRIG_W-1], ram_rdata});
      end
      S_V_RD4: begin
        op_a = $signed({4'b0, m_q});
        op_b = $signed({ram_rdata[TRIG_W-1], ram_rdata});
      end
      S_V_Z, S_V_OUT: begin
        op_a = $signed({13'b0, t2_q});
        op_b = $signed({sp_q[TRIG_W-1], sp_q});
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      face_pos <= CNT_W'(1);
      ring_pos <= CNT_W'(1);
      finished <= 1'b0;
      j        <= '0;
      k        <= '0;
      v        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && !fin_w) begin
            if (end_a) begin
              finished <= 1'b1;
              face_pos <= face_a;
              ring_pos <= ring_a;
            end else begin
              finished <= wrap_n && end_n;
              face_pos <= wrap_n ? CNT_W'(1) : face_n;
              ring_pos <= wrap_n ? ring_a + CNT_W'(1) : ring_a;
              j        <= '0;
              state    <= S_PHASE;
            end
          end
        end
        S_PHASE:   state <= S_PH_WAIT;
        S_PH_WAIT: if (!div_busy) state <= S_A;
        S_A: begin
          k     <= 3'd1;
          state <= S_X2;
        end
        S_X2:      state <= S_TS;
        S_TS:      state <= S_TS_WAIT;
        S_TS_WAIT: state <= S_TC;
        S_TC:      state <= S_TC_WAIT;
        S_TC_WAIT: begin
          if (k == 3'(TERMS)) begin
            state <= S_FIN;
          end else begin
            k     <= k + 3'd1;
            state <= S_TS;
          end
        end
        S_FIN:     state <= S_WR_COS;
        S_WR_COS: begin
          j <= j + 2'd1;
          if (j == 2'd3) begin
            v     <= '0;
            state <= S_V_RD0;
          end else begin
            state <= S_PHASE;
          end
        end
        S_V_RD0:   state <= S_V_RD1;
        S_V_RD1:   state <= S_V_RD2;
        S_V_RD2:   state <= S_V_RD3;
        S_V_RD3:   state <= S_V_RD4;
        S_V_RD4:   state <= S_V_Z;
        S_V_Z:     state <= S_V_OUT;
        S_V_OUT: begin
          if (out_load) begin
            v     <= v + 3'd1;
            state <= (v == 3'd5) ? S_IDLE : S_V_RD0;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_PH_WAIT: begin
        swap_q <= swap_c;
        quad_q <= div_quo[23:22];
      end
      S_A: begin
        ss <= {3'b0, a_c};
        ts <= {2'b0, a_c};
        sc <= 34'sh80000000;
        tc <= 33'h80000000;
      end
      S_X2: x2 <= x2_c;
      S_TS_WAIT: begin
        ts <= q_c;
        ss <= k[0] ? ss - $signed({1'b0, q_c}) : ss + $signed({1'b0, q_c});
      end
      S_TC_WAIT: begin
        tc <= q_c;
        sc <= k[0] ? sc - $signed({1'b0, q_c}) : sc + $signed({1'b0, q_c});
      end
      S_FIN:   cos_q <= cos_c;
      S_V_RD2: begin
        sp_q <= ram_rdata;
        m_q  <= a_v[55:24];
      end
      S_V_RD4: x_q <= rnd_sat(mul_p, 37);
      S_V_Z:   y_q <= rnd_sat(mul_p, 37);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vert_x       <= x_q;
      vert_y       <= y_q;
      vert_z       <= rnd_sat(mul_p, 31);
      last_of_quad <= (v == 3'd5);
      mesh_done    <= (v == 3'd5) && quad_done;
    end
  end

endmodule

// File: rtl/tvg_checker.sv
// port-level checks of the torus vertex generator, bound to the top level
// depends on tvg_pkg and torus_vertex_generator_core_assert.svh
module tvg_checker
  import tvg_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [VERT_W-1:0] vert_x,
  input logic signed [VERT_W-1:0] vert_y,
  input logic signed [VERT_W-1:0] vert_z,
  input logic                     last_of_quad,
  input logic                     mesh_done
);

`include "torus_vertex_generator_core_assert.svh"

  `TVG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "out word dropped")
  `TVG_ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(vert_x) && $stable(vert_y) && $stable(vert_z) && $stable(last_of_quad) && $stable(mesh_done), "out word changed")
  `TVG_ASSERT_IMP(a_done_last, clk, rst, out_valid && mesh_done, last_of_quad, "mesh end off quad end")
  `TVG_ASSERT_RST(a_rst_idle, clk, rst, !out_valid && in_ready, "not idle after reset")

endmodule

bind torus_vertex_generator_core tvg_checker u_tvg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .vert_x      (vert_x),
  .vert_y      (vert_y),
  .vert_z      (vert_z),
  .last_of_quad(last_of_quad),
  .mesh_done   (mesh_done)
);
